// ----- rtl/core/ppab_pkg.sv -----
package ppab_pkg;

  localparam int unsigned CH_BITS   = 8;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_BITS-1:0] RST_RED_MASK   = 32'h00FF_0000;
  localparam logic [WORD_BITS-1:0] RST_GREEN_MASK = 32'h0000_FF00;
  localparam logic [WORD_BITS-1:0] RST_BLUE_MASK  = 32'h0000_00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MASK     = 3'd0,
    REG_GREEN_MASK   = 3'd1,
    REG_BLUE_MASK    = 3'd2,
    REG_PIXEL_FORMAT = 3'd3,
    REG_MSB_FIRST    = 3'd4
  } ppab_reg_t;

  typedef enum logic [1:0] {
    FMT_PALETTE   = 2'd0,
    FMT_TWO_BYTE  = 2'd1,
    FMT_FOUR_BYTE = 2'd2
  } ppab_fmt_t;

  // ls: 0..32, rs: 0..8
  typedef struct packed {
    logic [5:0] ls;
    logic [3:0] rs;
  } ppab_shift_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] src_r;
    logic [7:0] src_g;
    logic [7:0] src_b;
    logic [7:0] old_r;
    logic [7:0] old_g;
    logic [7:0] old_b;
    logic [7:0] inv_alpha;
    logic [31:0] packed_src;
  } ppab_s1_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  src_r;
    logic [7:0]  src_g;
    logic [7:0]  src_b;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    logic [31:0] packed_src;
  } ppab_s2_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  col_r;
    logic [7:0]  col_g;
    logic [7:0]  col_b;
    logic [31:0] packed_src;
  } ppab_s3_t;

  // Trailing zero count, 32 for an all-zero word
  function automatic logic [5:0] tz32(input logic [WORD_BITS-1:0] m);
    logic [5:0] n;
    n = 6'd32;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (m[i]) begin
        n = 6'(i);
      end
    end
    return n;
  endfunction

  function automatic ppab_shift_t mask_shift(input logic [WORD_BITS-1:0] m);
    logic [5:0]           tz;
    logic [5:0]           run;
    logic [WORD_BITS-1:0] x;
    ppab_shift_t          sh;
    tz  = tz32(m);
    x   = m >> tz;
    run = tz32(~x);
    if (run > 6'(CH_BITS)) begin
      // run wider than a channel: drop the low bits of the field
      sh.ls = tz + run - 6'(CH_BITS);
      sh.rs = 4'd0;
    end else begin
      sh.ls = tz;
      sh.rs = 4'(6'(CH_BITS) - run);
    end
    return sh;
  endfunction

  function automatic logic [WORD_BITS-1:0] pack_chan(input logic [7:0] c,
                                                     input ppab_shift_t sh);
    logic [WORD_BITS-1:0] w;
    w = {24'd0, c >> sh.rs};
    return w << sh.ls;
  endfunction

  function automatic logic [7:0] extract_chan(input logic [WORD_BITS-1:0] v,
                                              input ppab_shift_t sh);
    logic [WORD_BITS-1:0] w;
    w = (v >> sh.ls) << sh.rs;
    return w[7:0];
  endfunction

  // Memory byte order to native value (and back: the mapping is its own inverse)
  function automatic logic [WORD_BITS-1:0] reorder(input logic [WORD_BITS-1:0] b,
                                                   input logic [1:0] fmt,
                                                   input logic msb);
    logic [WORD_BITS-1:0] v;
    if (fmt == FMT_PALETTE) begin
      v = {24'd0, b[7:0]};
    end else if (fmt == FMT_TWO_BYTE) begin
      v = msb ? {16'd0, b[7:0], b[15:8]} : {16'd0, b[15:0]};
    end else begin
      v = msb ? {b[7:0], b[15:8], b[23:16], b[31:24]} : b;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/ppab_in_if.sv -----
interface ppab_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [31:0] old_bytes;

  modport source (output valid, output mode, output red, output green, output blue,
                  output alpha, output old_bytes, input ready);
  modport sink (input valid, input mode, input red, input green, input blue,
                input alpha, input old_bytes, output ready);
endinterface

// ----- rtl/core/ppab_out_if.sv -----
interface ppab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_bytes;
  logic [31:0] pixel_value;

  modport source (output valid, output new_bytes, output pixel_value, input ready);
  modport sink (input valid, input new_bytes, input pixel_value, output ready);
endinterface

// ----- rtl/core/pixel_pack_and_alpha_blend.sv -----
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid/ready   | mode, red, green, blue, alpha, old_bytes
// out_ch   | out | valid/ready   | new_bytes, pixel_value
// cfg      | in  | cfg_we        | cfg_index, cfg_wdata (write only)
//
// Four register stages: extract, multiply, divide by 255 and add, pack.
// One request per clock while out_ch is not stalled; out_ch.valid rises once a request has passed every stage.
// Channel shifts are worked out when a mask is written and held in registers.
// rst_n is synchronous; it empties the pipe and restores the reset masks.
// A stall on out_ch holds the last stage; bubbles in earlier stages still fill.
module pixel_pack_and_alpha_blend (
  input  logic                             clk,
  input  logic                             rst_n,
  ppab_in_if.sink                          in_ch,
  ppab_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ppab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppab_pkg::WORD_BITS-1:0]   cfg_wdata
);

  ppab_pkg::ppab_shift_t shift_r [3];
  logic [1:0]            fmt_r;
  logic                  msb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r[0] <= ppab_pkg::mask_shift(ppab_pkg::RST_RED_MASK);
      shift_r[1] <= ppab_pkg::mask_shift(ppab_pkg::RST_GREEN_MASK);
      shift_r[2] <= ppab_pkg::mask_shift(ppab_pkg::RST_BLUE_MASK);
      fmt_r      <= ppab_pkg::FMT_FOUR_BYTE;
      msb_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppab_pkg::REG_RED_MASK:     shift_r[0] <= ppab_pkg::mask_shift(cfg_wdata);
        ppab_pkg::REG_GREEN_MASK:   shift_r[1] <= ppab_pkg::mask_shift(cfg_wdata);
        ppab_pkg::REG_BLUE_MASK:    shift_r[2] <= ppab_pkg::mask_shift(cfg_wdata);
        ppab_pkg::REG_PIXEL_FORMAT: fmt_r      <= cfg_wdata[1:0];
        ppab_pkg::REG_MSB_FIRST:    msb_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic is_pal;
  assign is_pal = (fmt_r == ppab_pkg::FMT_PALETTE);

  // pipe control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: old pixel to native value, channel extraction, source pack
  ppab_pkg::ppab_s1_t s1_nxt, s1_r;
  logic [31:0]        old_v;

  always_comb begin
    old_v = ppab_pkg::reorder(in_ch.old_bytes, fmt_r, msb_r);
    if (is_pal) begin
      old_v = {24'd0, ~old_v[7:0]};
    end
    s1_nxt.mode       = in_ch.mode;
    s1_nxt.src_r      = in_ch.red;
    s1_nxt.src_g      = in_ch.green;
    s1_nxt.src_b      = in_ch.blue;
    s1_nxt.old_r      = ppab_pkg::extract_chan(old_v, shift_r[0]);
    s1_nxt.old_g      = ppab_pkg::extract_chan(old_v, shift_r[1]);
    s1_nxt.old_b      = ppab_pkg::extract_chan(old_v, shift_r[2]);
    s1_nxt.inv_alpha  = ~in_ch.alpha;
    s1_nxt.packed_src = ppab_pkg::pack_chan(in_ch.red, shift_r[0])
                      | ppab_pkg::pack_chan(in_ch.green, shift_r[1])
                      | ppab_pkg::pack_chan(in_ch.blue, shift_r[2]);
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
  end

  // stage 2: old channel times (255 - alpha)
  ppab_pkg::ppab_s2_t s2_nxt, s2_r;

  always_comb begin
    s2_nxt.mode       = s1_r.mode;
    s2_nxt.src_r      = s1_r.src_r;
    s2_nxt.src_g      = s1_r.src_g;
    s2_nxt.src_b      = s1_r.src_b;
    s2_nxt.prod_r     = {8'd0, s1_r.old_r} * {8'd0, s1_r.inv_alpha};
    s2_nxt.prod_g     = {8'd0, s1_r.old_g} * {8'd0, s1_r.inv_alpha};
    s2_nxt.prod_b     = {8'd0, s1_r.old_b} * {8'd0, s1_r.inv_alpha};
    s2_nxt.packed_src = s1_r.packed_src;
  end

  always_ff @(posedge clk) begin
    if (rdy2) s2_r <= s2_nxt;
  end

  // stage 3: floor(p / 255) = (p + (p >> 8) + 1) >> 8, exact for p <= 255 * 255, added to the source channel
  ppab_pkg::ppab_s3_t s3_nxt, s3_r;
  logic [15:0]        qs_r, qs_g, qs_b;

  always_comb begin
    qs_r = s2_r.prod_r + {8'd0, s2_r.prod_r[15:8]} + 16'd1;
    qs_g = s2_r.prod_g + {8'd0, s2_r.prod_g[15:8]} + 16'd1;
    qs_b = s2_r.prod_b + {8'd0, s2_r.prod_b[15:8]} + 16'd1;
    s3_nxt.mode       = s2_r.mode;
    s3_nxt.col_r      = s2_r.src_r + qs_r[15:8];
    s3_nxt.col_g      = s2_r.src_g + qs_g[15:8];
    s3_nxt.col_b      = s2_r.src_b + qs_b[15:8];
    s3_nxt.packed_src = s2_r.packed_src;
  end

  always_ff @(posedge clk) begin
    if (rdy3) s3_r <= s3_nxt;
  end

  // stage 4: pack, cut to pixel width, memory byte order
  logic [31:0] res, new_bytes_nxt, pixel_value_nxt;
  logic [31:0] new_bytes_r, pixel_value_r;

  always_comb begin
    if (s3_r.mode) begin
      res = ppab_pkg::pack_chan(s3_r.col_r, shift_r[0])
          | ppab_pkg::pack_chan(s3_r.col_g, shift_r[1])
          | ppab_pkg::pack_chan(s3_r.col_b, shift_r[2]);
    end else begin
      res = s3_r.packed_src;
    end
    new_bytes_nxt = ppab_pkg::reorder(res, fmt_r, msb_r);
    if (is_pal) begin
      new_bytes_nxt   = {24'd0, ~res[7:0]};
      pixel_value_nxt = 32'd255 - s3_r.packed_src;
    end else begin
      pixel_value_nxt = s3_r.packed_src;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      new_bytes_r   <= new_bytes_nxt;
      pixel_value_r <= pixel_value_nxt;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.new_bytes   = new_bytes_r;
  assign out_ch.pixel_value = pixel_value_r;

endmodule

// ----- rtl/core/ppab_checker.sv -----
module ppab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_bytes,
  input logic [31:0] out_pixel_value
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_bytes)
                                && $stable(out_pixel_value))
    else $error("result changed under stall");

  // a free output side never throttles the input
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input throttled while output side is free");

  // a request accepted while the output side stays free reaches out_valid after passing every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("request not delivered after four cycles");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind pixel_pack_and_alpha_blend ppab_checker u_ppab_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_new_bytes   (out_ch.new_bytes),
  .out_pixel_value (out_ch.pixel_value)
);
